@@ hw/rtl/cfd_pkg.sv @@
// Shared types and constants for the command frame deframer.
package cfd_pkg;

  localparam logic [7:0] HdrByte  = 8'hAB;
  localparam logic [7:0] LenByte  = 8'h02;
  localparam logic [7:0] TailByte = 8'h55;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhLength  = 2'd1,
    PhPayload = 2'd2,
    PhTail    = 2'd3
  } phase_e;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdRead = 1'b1
  } cmd_e;

  // One request held in the input register.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] rx_byte;
  } req_t;

  // Mailbox contents as seen by a read request.
  typedef struct packed {
    logic       full;
    logic [7:0] code;
    logic [7:0] value;
  } mbox_t;

endpackage

@@ hw/rtl/cfd_parser.sv @@
// Frame parser state machine, payload store and command mailbox.
module cfd_parser import cfd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  req_t  req_i,
  output mbox_t mbox_o
);

  phase_e     phase_q, phase_d;
  logic       idx_q, idx_d;
  logic [7:0] pay_q [2];
  logic       pay_we;
  logic       mbox_load;
  mbox_t      mbox_q, mbox_d;
  logic       is_byte;
  logic [7:0] b;

  assign is_byte = step_i && (req_i.cmd == CmdByte);
  assign b       = req_i.rx_byte;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (is_byte) begin
      unique case (phase_q)
        PhHeader: begin
          if (b == HdrByte) phase_d = PhLength;
        end
        PhLength: begin
          if (b == LenByte)      phase_d = PhPayload;
          else if (b == HdrByte) phase_d = PhLength;
          else                   phase_d = PhHeader;
        end
        PhPayload: begin
          if (idx_q) phase_d = PhTail;
        end
        PhTail: begin
          if (b == TailByte)     phase_d = PhHeader;
          else if (b == HdrByte) phase_d = PhLength;
          else                   phase_d = PhHeader;
        end
        default: phase_d = PhHeader;
      endcase
    end
  end

  // Phase-dependent actions.
  always_comb begin
    pay_we    = 1'b0;
    mbox_load = 1'b0;
    idx_d     = idx_q;
    if (is_byte) begin
      unique case (phase_q)
        PhLength: begin
          if (b == LenByte) idx_d = 1'b0;
        end
        PhPayload: begin
          pay_we = 1'b1;
          idx_d  = ~idx_q;
        end
        PhTail: begin
          mbox_load = (b == TailByte);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mbox_d = mbox_q;
    if (mbox_load) begin
      mbox_d.full  = 1'b1;
      mbox_d.code  = pay_q[0];
      mbox_d.value = pay_q[1];
    end else if (step_i && (req_i.cmd == CmdRead)) begin
      mbox_d.full = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      idx_q   <= 1'b0;
      mbox_q  <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      mbox_q  <= mbox_d;
    end
  end

  // Payload store: written before any tail can read it, so no reset.
  always_ff @(posedge clk_i) begin
    if (pay_we) pay_q[idx_q] <= b;
  end

  assign mbox_o = mbox_q;

endmodule

@@ hw/rtl/cfd_out_stage.sv @@
// Result register holding one mailbox report until the sink takes it.
module cfd_out_stage import cfd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  mbox_t data_i,
  output logic  free_o,
  input  logic  ready_i,
  output logic  valid_o,
  output mbox_t data_o
);

  logic  valid_q;
  mbox_t data_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) data_q <= data_i;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hw/rtl/command_frame_deframer_top.sv @@
// Top level of the command frame deframer: input register, parser, result register.
//
//  Channel  Dir  tdata                               tuser
//  s_axis   in   [7:0] rx_byte                       [0] cmd (0 byte, 1 read)
//  m_axis   out  [7:0] command_code, [15:8] value    [0] new_command
//
// One request a cycle: a request lands in the input register, is parsed from it by
// the parser, and a read request's report lands in the result register. Byte
// requests give no result. Reset clears the frame phase, the mailbox and both valid
// flags. A stalled sink holds only read requests; byte requests keep flowing past a
// waiting result.
module command_frame_deframer_top import cfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] command_code, [15:8] command_value
  output logic        m_axis_tuser_o    // [0] new_command
);

  logic  in_valid_q;
  req_t  req_q;
  logic  out_free;
  logic  adv;
  mbox_t mbox;
  mbox_t out_data;

  // Advance the held request unless it is a read facing a full result register.
  assign adv             = in_valid_q && ((req_q.cmd == CmdByte) || out_free);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Hold the payload of the request; no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      req_q.cmd     <= cmd_e'(s_axis_tuser_i);
      req_q.rx_byte <= s_axis_tdata_i;
    end
  end

  cfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .req_i  (req_q),
    .mbox_o (mbox)
  );

  cfd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && (req_q.cmd == CmdRead)),
    .data_i  (mbox),
    .free_o  (out_free),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .data_o  (out_data)
  );

  assign m_axis_tuser_o = out_data.full;
  assign m_axis_tdata_o = {out_data.value, out_data.code};

`ifndef SYNTH
  // A read request always leaves the mailbox flag clear.
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (req_q.cmd == CmdRead)) |=> !mbox.full)
    else $error("mailbox flag still set after read");

  // Only a byte request can set the mailbox flag.
  a_full_by_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mbox.full) |-> $past(adv && (req_q.cmd == CmdByte)))
    else $error("mailbox flag set without a byte request");

  // Input is back-pressured only while a held read faces a full result register.
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && (req_q.cmd == CmdRead) && m_axis_tvalid_o))
    else $error("input stalled without a blocked read");
`endif

endmodule

@@ verif/cfd_report_checker.sv @@
`timescale 1ns / 1ps
// Mailbox predictor and report checker for the command frame deframer.
module cfd_report_checker import cfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] cmd
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [7:0] command_code, [15:8] command_value
  input  logic        m_axis_tuser_i,   // [0] new_command
  output int          fail_count_o,
  output int          outstanding_o,
  output int          reports_o,
  output int          fresh_reports_o,
  output int          frames_o
);

  phase_e     phase;
  logic [1:0] payload_cnt;
  logic [7:0] payload_buf [2];
  mbox_t      mailbox;
  mbox_t      report_q [$];

  task automatic parse_rx_byte(input logic [7:0] b);
    case (phase)
      PhHeader: begin
        if (b == HdrByte) phase = PhLength;
      end
      PhLength: begin
        if (b == LenByte) begin
          payload_cnt = '0;
          phase       = PhPayload;
        end else begin
          phase = (b == HdrByte) ? PhLength : PhHeader;
        end
      end
      PhPayload: begin
        payload_buf[payload_cnt[0]] = b;
        payload_cnt = payload_cnt + 2'd1;
        if (8'(payload_cnt) >= LenByte) phase = PhTail;
      end
      default: begin
        if (b == TailByte) begin
          mailbox.code  = payload_buf[0];
          mailbox.value = payload_buf[1];
          mailbox.full  = 1'b1;
          phase         = PhHeader;
          frames_o++;
        end else begin
          phase = (b == HdrByte) ? PhLength : PhHeader;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mbox_t want;
    if (!rst_ni) begin
      phase           = PhHeader;
      payload_cnt     = '0;
      payload_buf[0]  = '0;
      payload_buf[1]  = '0;
      mailbox         = '0;
      report_q.delete();
      fail_count_o    = 0;
      reports_o       = 0;
      fresh_reports_o = 0;
      frames_o        = 0;
      outstanding_o  <= 0;
    end else begin
      // Retire the report first, so a read accepted in the same cycle cannot pair with it.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (report_q.size() == 0) begin
          $error("report with none outstanding: new_command %0d code %02h value %02h",
                 m_axis_tuser_i, m_axis_tdata_i[7:0], m_axis_tdata_i[15:8]);
          fail_count_o++;
        end else begin
          want = report_q.pop_front();
          reports_o++;
          if (want.full) fresh_reports_o++;
          if (m_axis_tuser_i !== want.full) begin
            $error("new_command: expected %0d, got %0d", want.full, m_axis_tuser_i);
            fail_count_o++;
          end
          if (m_axis_tdata_i[7:0] !== want.code) begin
            $error("command_code: expected %02h, got %02h", want.code, m_axis_tdata_i[7:0]);
            fail_count_o++;
          end
          if (m_axis_tdata_i[15:8] !== want.value) begin
            $error("command_value: expected %02h, got %02h", want.value,
                   m_axis_tdata_i[15:8]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (cmd_e'(s_axis_tuser_i) == CmdRead) begin
          report_q.push_back(mailbox);
          mailbox.full = 1'b0;
        end else begin
          parse_rx_byte(s_axis_tdata_i);
        end
      end
      outstanding_o <= report_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Stimulus, handshake pressure and verdict for the command frame deframer.
module testbench;
  import cfd_pkg::*;

  localparam int ItemTarget = 850;  // requests to send before draining
  localparam int CalmFrom   = 700;  // no idling on either side beyond this request
  localparam int StallLimit = 2000; // cycles without any handshake before giving up
  localparam int TailCycles = 20;   // settle time once nothing is outstanding

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [7:0] rx_byte
  logic        s_axis_tuser_i  = 1'b0; // [0] cmd
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b1;
  logic [15:0] m_axis_tdata_o;         // [7:0] command_code, [15:8] command_value
  logic        m_axis_tuser_o;         // [0] new_command

  int fail_count, outstanding, reports, fresh_reports, frames;
  int sent       = 0;
  int gap_pct    = 0;  // chance of a sender gap before a request
  int stall_pct  = 0;  // chance per cycle of a sink stall burst
  bit calm       = 1'b0;
  int idle_count = 0;

  // Free-running clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  command_frame_deframer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  cfd_report_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .reports_o       (reports),
    .fresh_reports_o (fresh_reports),
    .frames_o        (frames)
  );

  // Drop tready in random bursts; hold it high once the run turns calm.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Abort when neither channel has moved a request for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_count <= 0;
      end else if (idle_count >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles", StallLimit);
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // Present one request and hold it until the block takes it, after an optional gap.
  task automatic send_request(input cmd_e kind, input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
    calm = (sent >= CalmFrom);
  endtask

  // Read request; the byte lane carries noise the block must ignore.
  task automatic send_read();
    send_request(CmdRead, 8'($urandom));
  endtask

  // Byte biased towards the framing constants and the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0:       return HdrByte;
      1:       return LenByte;
      2:       return TailByte;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Whole frame, with the odd read slipped in between its bytes.
  task automatic send_frame(input logic [7:0] code, input logic [7:0] value);
    logic [7:0] seq [5];
    seq = '{HdrByte, LenByte, code, value, TailByte};
    foreach (seq[i]) begin
      if ($urandom_range(0, 99) < 5) send_read();
      send_request(CmdByte, seq[i]);
    end
  endtask

  initial begin
    logic [7:0] b;
    int         kind, cut;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty mailbox after reset, extreme payload, read of a consumed mailbox.
    send_read();
    send_frame(8'hFF, 8'h00);
    send_read();
    send_read();
    // Bad length that is not a header byte drops back to hunting for a header.
    send_request(CmdByte, HdrByte);
    send_request(CmdByte, 8'h03);
    // Header in the length slot keeps waiting for the length.
    send_request(CmdByte, HdrByte);
    send_request(CmdByte, HdrByte);
    send_request(CmdByte, LenByte);
    send_request(CmdByte, 8'h01);
    send_request(CmdByte, 8'h80);
    // Bad tail, plain byte: mailbox untouched.
    send_request(CmdByte, 8'h00);
    // Bad tail that is a header byte restarts at the length phase.
    send_request(CmdByte, HdrByte);
    send_request(CmdByte, LenByte);
    send_request(CmdByte, HdrByte);
    send_request(CmdByte, TailByte);
    send_request(CmdByte, HdrByte);
    send_request(CmdByte, LenByte);
    send_request(CmdByte, 8'h7E);
    send_request(CmdByte, 8'h81);
    send_request(CmdByte, TailByte);
    // Two unread frames: the newer one wins.
    send_frame(8'hAB, 8'h55);
    send_read();

    // Random part: mostly well-formed frames, the rest broken frames, noise and reads.
    while (sent < ItemTarget) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 5;  stall_pct = 3;  end
          default: begin gap_pct = 30; stall_pct = 12; end
        endcase
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_frame(pick_byte(), pick_byte());
        if ($urandom_range(0, 9) < 7) send_read();
      end else if (kind < 70) begin
        cut = $urandom_range(0, 3);
        send_request(CmdByte, HdrByte);
        if (cut == 0) begin
          do b = pick_byte(); while (b == LenByte);
          send_request(CmdByte, b);
        end else begin
          send_request(CmdByte, LenByte);
          send_request(CmdByte, pick_byte());
          if (cut >= 2) send_request(CmdByte, pick_byte());
          if (cut == 3) begin
            do b = pick_byte(); while (b == TailByte);
            send_request(CmdByte, b);
          end
        end
        if ($urandom_range(0, 1)) send_read();
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4)) send_request(CmdByte, pick_byte());
      end else begin
        send_read();
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain: let the last request reach the checker, then wait for every report.
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("summary: %0d requests sent, %0d good frames latched", sent, frames);
    $display("summary: %0d mailbox reports checked, %0d of them carrying a new command",
             reports, fresh_reports);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
